[rtl/rrds_pkg.sv]
// Shared types and constants of the round-robin delay scheduler.
package rrds_pkg;

  localparam int DELAY_W  = 32;
  localparam int ACTIVE_W = 4;
  localparam int CHOSEN_W = 3;

  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_DELAY = 1'b1;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 4'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_TICK,
    ST_DELAY,
    ST_SEARCH,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [CHOSEN_W-1:0] chosen_task;
    logic                switch_request;
  } result_t;

endpackage

[rtl/rrds_ctrl.sv]
// Sequencer with the sleep counter memory: tick sweep, delay load and round-robin search.
module rrds_ctrl #(
  parameter int NUM_TASKS = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            req_type,
  input  logic [rrds_pkg::DELAY_W-1:0]    delay_amount,
  input  logic [rrds_pkg::ACTIVE_W-1:0]   active_tasks,
  output logic                            res_valid,
  input  logic                            res_ready,
  output rrds_pkg::result_t               res
);

  localparam int IW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int CW = ((IW > rrds_pkg::ACTIVE_W) ? IW : rrds_pkg::ACTIVE_W) + 1;

  rrds_pkg::state_t state, state_next;

  logic                         req_q, req_next;
  logic [rrds_pkg::DELAY_W-1:0] amt_q, amt_next;
  logic [IW-1:0]                running, running_next;
  logic [IW-1:0]                rm, rm_next;
  logic [CW-1:0]                idx, idx_next;
  logic [CW-1:0]                issued, issued_next;
  logic [IW-1:0]                cand, cand_next;
  logic                         pend, pend_next;
  logic [IW-1:0]                pend_idx, pend_idx_next;
  logic [IW-1:0]                chosen, chosen_next;

  // Sleep counter memory; an entry never written reads as zero through its valid bit.
  logic [rrds_pkg::DELAY_W-1:0] mem [NUM_TASKS];
  logic [NUM_TASKS-1:0]         vld;
  logic [rrds_pkg::DELAY_W-1:0] rd_data;
  logic                         rd_vld;
  logic [rrds_pkg::DELAY_W-1:0] rd_value;
  logic                         mem_we, mem_re;
  logic [IW-1:0]                mem_waddr, mem_raddr;
  logic [rrds_pkg::DELAY_W-1:0] mem_wdata;

  logic [rrds_pkg::ACTIVE_W-1:0] cnt;
  logic [CW-1:0]                 cnt_ext, rm_ext, rm_diff;
  logic [IW-1:0]                 start_idx, cand_inc;
  logic                          hit;
  logic [IW+rrds_pkg::CHOSEN_W-1:0] chosen_wide;

  always_comb begin
    if (active_tasks == '0) begin
      cnt = rrds_pkg::ACTIVE_W'(1);
    end else if (32'(active_tasks) > 32'(NUM_TASKS)) begin
      cnt = rrds_pkg::ACTIVE_W'(NUM_TASKS);
    end else begin
      cnt = active_tasks;
    end
  end

  assign cnt_ext  = CW'(cnt);
  assign rm_ext   = CW'(rm);
  assign rm_diff  = rm_ext - cnt_ext;
  assign rd_value = rd_vld ? rd_data : '0;
  assign hit      = pend && (rd_value == '0);

  // Search starts just after the running task, reduced modulo the task count.
  assign start_idx = (rm_ext + CW'(1) == cnt_ext) ? '0 : rm + IW'(1);
  assign cand_inc  = (CW'(cand) + CW'(1) == cnt_ext) ? '0 : cand + IW'(1);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
      rd_vld  <= vld[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (mem_we) begin
      vld[mem_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= rrds_pkg::ST_IDLE;
      running <= '0;
      pend    <= 1'b0;
    end else begin
      state   <= state_next;
      running <= running_next;
      pend    <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    req_q    <= req_next;
    amt_q    <= amt_next;
    rm       <= rm_next;
    idx      <= idx_next;
    issued   <= issued_next;
    cand     <= cand_next;
    pend_idx <= pend_idx_next;
    chosen   <= chosen_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      rrds_pkg::ST_IDLE: begin
        if (in_valid) state_next = rrds_pkg::ST_MOD;
      end
      rrds_pkg::ST_MOD: begin
        if (rm_ext < cnt_ext) begin
          state_next = (req_q == rrds_pkg::REQ_DELAY) ? rrds_pkg::ST_DELAY : rrds_pkg::ST_TICK;
        end
      end
      rrds_pkg::ST_TICK: begin
        if (idx == cnt_ext && !pend) state_next = rrds_pkg::ST_SEARCH;
      end
      rrds_pkg::ST_DELAY: begin
        state_next = rrds_pkg::ST_SEARCH;
      end
      rrds_pkg::ST_SEARCH: begin
        if (hit || issued == cnt_ext) state_next = rrds_pkg::ST_DONE;
      end
      rrds_pkg::ST_DONE: begin
        if (res_ready) state_next = rrds_pkg::ST_IDLE;
      end
      default: state_next = rrds_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    res_valid     = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_waddr     = pend_idx;
    mem_raddr     = cand;
    mem_wdata     = amt_q;
    req_next      = req_q;
    amt_next      = amt_q;
    running_next  = running;
    rm_next       = rm;
    idx_next      = idx;
    issued_next   = issued;
    cand_next     = cand;
    pend_next     = pend;
    pend_idx_next = pend_idx;
    chosen_next   = chosen;
    unique case (state)
      rrds_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          req_next  = req_type;
          amt_next  = delay_amount;
          rm_next   = running;
          idx_next  = '0;
          pend_next = 1'b0;
        end
      end
      rrds_pkg::ST_MOD: begin
        // Repeated subtraction; only runs long after the task count is lowered.
        if (rm_ext >= cnt_ext) rm_next = rm_diff[IW-1:0];
      end
      rrds_pkg::ST_TICK: begin
        // Read one counter per cycle and write the previous one back in the cycle after its read.
        if (idx != cnt_ext) begin
          mem_re        = 1'b1;
          mem_raddr     = idx[IW-1:0];
          idx_next      = idx + CW'(1);
          pend_next     = 1'b1;
          pend_idx_next = idx[IW-1:0];
        end else begin
          pend_next = 1'b0;
        end
        if (pend) begin
          mem_we    = 1'b1;
          mem_waddr = pend_idx;
          mem_wdata = (rd_value != '0) ? rd_value - rrds_pkg::DELAY_W'(1) : '0;
        end
        if (idx == cnt_ext && !pend) begin
          cand_next   = start_idx;
          issued_next = '0;
        end
      end
      rrds_pkg::ST_DELAY: begin
        mem_we      = 1'b1;
        mem_waddr   = running;
        mem_wdata   = amt_q;
        cand_next   = start_idx;
        issued_next = '0;
        pend_next   = 1'b0;
      end
      rrds_pkg::ST_SEARCH: begin
        priority if (hit) begin
          chosen_next = pend_idx;
          pend_next   = 1'b0;
        end else if (issued == cnt_ext) begin
          // Nobody is ready: stay on the running task.
          chosen_next = rm;
          pend_next   = 1'b0;
        end else begin
          mem_re        = 1'b1;
          mem_raddr     = cand;
          pend_next     = 1'b1;
          pend_idx_next = cand;
          cand_next     = cand_inc;
          issued_next   = issued + CW'(1);
        end
      end
      rrds_pkg::ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) running_next = chosen;
      end
      default: begin
      end
    endcase
  end

  assign chosen_wide        = {{rrds_pkg::CHOSEN_W{1'b0}}, chosen};
  assign res.chosen_task    = chosen_wide[rrds_pkg::CHOSEN_W-1:0];
  assign res.switch_request = (chosen != running);

endmodule

[rtl/rrds_outbuf.sv]
// Output register that holds one finished result until the downstream side takes it.
module rrds_outbuf (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  rrds_pkg::result_t in_res,
  output logic              out_valid,
  input  logic              out_ready,
  output rrds_pkg::result_t out_res
);

  logic              full;
  rrds_pkg::result_t res_q;

  assign in_ready  = !full || out_ready;
  assign out_valid = full;
  assign out_res   = res_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (in_valid && in_ready) begin
      full <= 1'b1;
    end else if (out_ready) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) res_q <= in_res;
  end

endmodule

[rtl/round_robin_delay_scheduler_top.sv]
// Each item is accepted in idle, reduces the running task index modulo the clamped task count
// by repeated subtraction, then sweeps the counters (tick) or loads one (delay), searches
// the candidates round-robin and holds the result until the output register takes it.
// Throughput: one item at a time; the counter memory is walked once per task for a tick and
// once per candidate in the search. A result waits in an output register.
// Reset: synchronous; counters read as zero, running task 0, active task count 1.
module round_robin_delay_scheduler_top #(
  parameter int NUM_TASKS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [rrds_pkg::DELAY_W-1:0]  s_tdata,   // [31:0] delay_amount
  input  logic [0:0]                    s_tuser,   // [0] req_type
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [7:0]                    m_tdata,   // [2:0] chosen_task, [7:3] zero
  output logic [0:0]                    m_tuser,   // [0] switch_request
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rrds_pkg::ACTIVE_W-1:0] cfg_data   // active_tasks
);

  logic [rrds_pkg::ACTIVE_W-1:0] active_tasks;
  logic                          res_valid, res_ready;
  rrds_pkg::result_t             res, out_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_tasks <= rrds_pkg::ACTIVE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      active_tasks <= cfg_data;
    end
  end

  rrds_ctrl #(
    .NUM_TASKS(NUM_TASKS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .req_type     (s_tuser[0]),
    .delay_amount (s_tdata),
    .active_tasks (active_tasks),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res)
  );

  rrds_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (res_valid),
    .in_ready  (res_ready),
    .in_res    (res),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  assign m_tdata = {{(8 - rrds_pkg::CHOSEN_W){1'b0}}, out_res.chosen_task};
  assign m_tuser = out_res.switch_request;

endmodule

[rtl/rrds_chk.sv]
// Port-level checker for the scheduler, bound to the top level.
module rrds_chk (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic [0:0] m_tuser
);

  logic       s_xfer, m_xfer;
  logic [1:0] outstanding;
  logic [2:0] last_chosen;

  assign s_xfer = s_tvalid && s_tready;
  assign m_xfer = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
      last_chosen <= '0;
    end else begin
      outstanding <= outstanding + 2'(s_xfer) - 2'(m_xfer);
      if (m_xfer) last_chosen <= m_tdata[2:0];
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid straight after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_xfer |-> outstanding <= 2'd1)
    else $error("input taken with two items outstanding");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> outstanding != 2'd0)
    else $error("result without an accepted input");

  a_no_switch_same_task: assert property (@(posedge clk) disable iff (rst)
    m_xfer && !m_tuser[0] |-> m_tdata[2:0] == last_chosen)
    else $error("task changed without a switch request");

endmodule

bind round_robin_delay_scheduler_top rrds_chk u_rrds_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

[tb/testbench.sv]
// Self-checking testbench for the round-robin delay scheduler: directed and random requests.
module testbench;

  localparam int NTASK        = 8;
  localparam int HOLD_CYCLES  = 120;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int SEG_ITEMS    = 85;

  logic                          clk       = 1'b0;
  logic                          rst       = 1'b1;
  logic                          s_tvalid  = 1'b0;
  logic                          s_tready;
  logic [rrds_pkg::DELAY_W-1:0]  s_tdata   = '0;   // [31:0] delay_amount
  logic [0:0]                    s_tuser   = '0;   // [0] req_type
  logic                          m_tvalid;
  logic                          m_tready  = 1'b0;
  logic [7:0]                    m_tdata;          // [2:0] chosen_task, [7:3] zero
  logic [0:0]                    m_tuser;          // [0] switch_request
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [rrds_pkg::ACTIVE_W-1:0] cfg_data  = '0;

  // Scheduler state as the predictor sees it.
  logic [rrds_pkg::DELAY_W-1:0]  sleep_left [NTASK];
  int                            run_idx;
  logic [rrds_pkg::ACTIVE_W-1:0] active_cfg;
  rrds_pkg::result_t             chosen_q [$];

  int errors    = 0;
  int n_ticks   = 0;
  int n_delays  = 0;
  int n_results = 0;
  int n_cfg     = 0;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  bit hold_req      = 1'b0;
  int hold_left     = 0;
  int quiet         = 0;

  round_robin_delay_scheduler_top #(
    .NUM_TASKS(NTASK)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int tasks_in_use();
    int n;
    n = active_cfg;
    if (n == 0) n = 1;
    if (n > NTASK) n = NTASK;
    return n;
  endfunction

  // Applies one request to the task state and queues the scheduling decision.
  function automatic void schedule_next(logic kind, logic [rrds_pkg::DELAY_W-1:0] amount);
    int                n;
    int                pick;
    bit                found;
    rrds_pkg::result_t want;
    n = tasks_in_use();
    if (kind == rrds_pkg::REQ_TICK) begin
      for (int i = 0; i < n; i++) begin
        if (sleep_left[i] != 0) sleep_left[i] = sleep_left[i] - 1;
      end
      n_ticks++;
    end else begin
      sleep_left[run_idx] = amount;
      n_delays++;
    end
    // With nothing ready the search ends back on the running task, taken modulo the count.
    pick  = run_idx % n;
    found = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (!found) begin
        pick  = (run_idx + 1 + i) % n;
        found = (sleep_left[pick] == 0);
      end
    end
    want.chosen_task    = rrds_pkg::CHOSEN_W'(pick);
    want.switch_request = (pick != run_idx);
    run_idx = pick;
    chosen_q.push_back(want);
  endfunction

  function automatic void check_result();
    rrds_pkg::result_t want;
    n_results++;
    if (chosen_q.size() == 0) begin
      $error("result with no request waiting: chosen_task %0d",
             m_tdata[rrds_pkg::CHOSEN_W-1:0]);
      errors++;
    end else begin
      want = chosen_q.pop_front();
      if (m_tdata[rrds_pkg::CHOSEN_W-1:0] !== want.chosen_task) begin
        $error("chosen_task: expected %0d, actual %0d", want.chosen_task,
               m_tdata[rrds_pkg::CHOSEN_W-1:0]);
        errors++;
      end
      if (m_tuser[0] !== want.switch_request) begin
        $error("switch_request: expected %0d, actual %0d", want.switch_request, m_tuser[0]);
        errors++;
      end
    end
  endfunction

  // Result checker and receiver; a requested hold-off keeps tready low for a long stretch.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) check_result();
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Ends the run if no transfer of any kind happens for too long.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("testbench failed");
        $finish;
      end
    end
  end

  task automatic set_idling(int mode);
    case (mode)
      0: begin
        send_idle_pct = 0;
        stall_pct     = 0;
      end
      1: begin
        send_idle_pct = 72;
        stall_pct     = 0;
      end
      2: begin
        send_idle_pct = 0;
        stall_pct     = 72;
      end
      default: begin
        send_idle_pct = 27;
        stall_pct     = 27;
      end
    endcase
  endtask

  // The idle gap is chosen up front so that tvalid is never lowered and raised in one step.
  task automatic send_req(logic kind, logic [rrds_pkg::DELAY_W-1:0] amount);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= amount;
    do @(posedge clk); while (!s_tready);
    schedule_next(kind, amount);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (chosen_q.size() != 0);
  endtask

  task automatic write_active(logic [rrds_pkg::ACTIVE_W-1:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    active_cfg = value;
    n_cfg++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Long sleeps are only used while task 0 runs alone, since it is then always reloaded and
  // can never be left asleep for the rest of the run.
  task automatic random_req();
    logic                         kind;
    logic [rrds_pkg::DELAY_W-1:0] amount;
    bit                           wide;
    kind   = ($urandom_range(99) < 40) ? rrds_pkg::REQ_TICK : rrds_pkg::REQ_DELAY;
    amount = $urandom();
    wide   = (tasks_in_use() == 1) && (run_idx == 0) && ($urandom_range(1) == 1);
    if (kind == rrds_pkg::REQ_DELAY && !wide) begin
      amount = ($urandom_range(99) < 15) ? '0 : rrds_pkg::DELAY_W'($urandom_range(12, 1));
    end
    send_req(kind, amount);
  endtask

  task automatic test_directed();
    int guard;
    set_idling(0);
    // A single task: ticks on a ready counter, the longest sleep and a wake by zero delay.
    send_req(rrds_pkg::REQ_TICK, '0);
    send_req(rrds_pkg::REQ_DELAY, '1);
    send_req(rrds_pkg::REQ_TICK, 32'h5555_aaaa);
    send_req(rrds_pkg::REQ_DELAY, '0);
    write_active(4'd15);
    guard = 0;
    while (run_idx != NTASK - 1 && guard < 10) begin
      send_req(rrds_pkg::REQ_TICK, '0);
      guard++;
    end
    send_req(rrds_pkg::REQ_DELAY, 32'd2);
    send_req(rrds_pkg::REQ_DELAY, '0);
    guard = 0;
    while (run_idx != 6 && guard < 10) begin
      send_req(rrds_pkg::REQ_TICK, '0);
      guard++;
    end
    // The running task now lies beyond the lowered task count.
    write_active(4'd3);
    send_req(rrds_pkg::REQ_DELAY, 32'd9);
    send_req(rrds_pkg::REQ_TICK, '0);
    write_active(4'd0);
    send_req(rrds_pkg::REQ_TICK, '0);
    send_req(rrds_pkg::REQ_DELAY, 32'd4);
    wait_drained();
  endtask

  task automatic test_random();
    logic [rrds_pkg::ACTIVE_W-1:0] settings [12];
    settings = '{4'd8, 4'd1, 4'd15, 4'd3, 4'd0, 4'd6, 4'd9, 4'd2, 4'd5, 4'd8, 4'd4, 4'd7};
    for (int seg = 0; seg < 12; seg++) begin
      write_active(settings[seg]);
      set_idling(seg % 4);
      repeat (SEG_ITEMS) random_req();
      if (tasks_in_use() == 1 && run_idx == 0) send_req(rrds_pkg::REQ_DELAY, '0);
    end
    wait_drained();
  endtask

  task automatic test_backpressure();
    write_active(4'd8);
    set_idling(0);
    hold_req = 1'b1;
    repeat (24) random_req();
    wait_drained();
  endtask

  initial begin
    foreach (sleep_left[i]) sleep_left[i] = '0;
    run_idx    = 0;
    active_cfg = rrds_pkg::ACTIVE_RESET;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random();
    test_backpressure();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (chosen_q.size() != 0) begin
      $error("%0d expected results never arrived", chosen_q.size());
      errors++;
    end
    $display("Run covered %0d ticks and %0d delays with %0d results checked,", n_ticks,
             n_delays, n_results);
    $display("over %0d task-count writes including zero, above range and a long hold-off.",
             n_cfg);
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/rrds_pkg.sv
rtl/rrds_ctrl.sv
rtl/rrds_outbuf.sv
rtl/round_robin_delay_scheduler_top.sv
rtl/rrds_chk.sv
tb/testbench.sv
